@@ design/volume_brightness_key_repeat_defines.svh @@
`ifndef VOLUME_BRIGHTNESS_KEY_REPEAT_DEFINES_SVH
`define VOLUME_BRIGHTNESS_KEY_REPEAT_DEFINES_SVH

// same-cycle implication, checked on every clock edge out of reset
`define VBKR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vbkr check failed");

// next-cycle implication
`define VBKR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vbkr check failed");

`endif

@@ design/vbkr_pkg.sv @@
`timescale 1ns / 1ps

package vbkr_pkg;

    localparam int LEVEL_W = 6;
    localparam int MS_W    = 16;
    localparam int CLOCK_W = 32;
    localparam int CODE_W  = 10;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0]
    {
        OP_FRAME_BEGIN = 2'd0,
        OP_KEY_EVENT   = 2'd1,
        OP_FRAME_END   = 2'd2,
        OP_LOAD        = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        KEY_RELEASE = 2'd0,
        KEY_PRESS   = 2'd1,
        KEY_REPEAT  = 2'd2,
        KEY_IGNORED = 2'd3
    } key_value_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_REPEAT_DELAY    = 3'd0,
        REG_REPEAT_INTERVAL = 3'd1,
        REG_STALE_GAP       = 3'd2,
        REG_VOLUME_TOP      = 3'd3,
        REG_BRIGHTNESS_TOP  = 3'd4
    } reg_idx_t;

    localparam logic [CODE_W-1:0] CODE_MENU_A   = 10'd317;
    localparam logic [CODE_W-1:0] CODE_MENU_B   = 10'd318;
    localparam logic [CODE_W-1:0] CODE_VOL_UP   = 10'd114;
    localparam logic [CODE_W-1:0] CODE_VOL_DOWN = 10'd115;

    localparam logic [MS_W-1:0]    RST_REPEAT_DELAY    = 16'd300;
    localparam logic [MS_W-1:0]    RST_REPEAT_INTERVAL = 16'd100;
    localparam logic [MS_W-1:0]    RST_STALE_GAP       = 16'd1000;
    localparam logic [LEVEL_W-1:0] RST_VOLUME_TOP      = 6'd20;
    localparam logic [LEVEL_W-1:0] RST_BRIGHTNESS_TOP  = 6'd10;

endpackage

@@ design/volume_brightness_key_repeat.sv @@
// an accepted word is held in the input register, then its result in the output register
// throughput: one word per cycle unless the output stalls; state and levels are registered
// a waiting result stalls the input once the input register also holds a word
// reset: async active low; levels, clock, key state cleared, registers to defaults
// configuration writes are registered and always ready
`timescale 1ns / 1ps

module volume_brightness_key_repeat
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        op,
    input  logic [vbkr_pkg::MS_W-1:0]         elapsed_ms,
    input  logic                              is_key_event,
    input  logic [vbkr_pkg::CODE_W-1:0]       key_code,
    input  logic [1:0]                        key_value,
    input  logic [vbkr_pkg::LEVEL_W-1:0]      load_volume,
    input  logic [vbkr_pkg::LEVEL_W-1:0]      load_brightness,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [vbkr_pkg::LEVEL_W-1:0]      volume_level,
    output logic [vbkr_pkg::LEVEL_W-1:0]      brightness_level,
    output logic                              volume_changed,
    output logic                              brightness_changed,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vbkr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vbkr_pkg::MS_W-1:0]         cfg_data
);

    localparam int LW = vbkr_pkg::LEVEL_W;
    localparam int MW = vbkr_pkg::MS_W;
    localparam int CW = vbkr_pkg::CLOCK_W;

    // configuration
    logic [MW-1:0] repeat_delay_reg;
    logic [MW-1:0] repeat_interval_reg;
    logic [MW-1:0] stale_gap_reg;
    logic [LW-1:0] volume_top_reg;
    logic [LW-1:0] brightness_top_reg;

    // input stage
    logic                          s1_valid_reg;
    vbkr_pkg::op_t                 s1_op_reg;
    logic [MW-1:0]                 s1_elapsed_reg;
    logic                          s1_is_key_reg;
    logic [vbkr_pkg::CODE_W-1:0]   s1_code_reg;
    vbkr_pkg::key_value_t          s1_value_reg;
    logic [LW-1:0]                 s1_load_vol_reg;
    logic [LW-1:0]                 s1_load_bri_reg;

    // key state
    logic [CW-1:0] clock_reg,      clock_next;
    logic          stale_reg,      stale_next;
    logic          menu_reg,       menu_next;
    logic          plus_held_reg,  plus_held_next;
    logic          plus_fresh_reg, plus_fresh_next;
    logic [CW-1:0] plus_due_reg,   plus_due_next;
    logic          minus_held_reg, minus_held_next;
    logic          minus_fresh_reg, minus_fresh_next;
    logic [CW-1:0] minus_due_reg,  minus_due_next;
    logic [LW-1:0] volume_reg,     volume_next;
    logic [LW-1:0] bright_reg,     bright_next;

    // output stage
    logic          out_valid_reg;
    logic [LW-1:0] out_vol_reg;
    logic [LW-1:0] out_bri_reg;
    logic          out_vol_chg_reg;
    logic          out_bri_chg_reg;

    logic in_accept;
    logic out_load;

    assign out_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || out_load;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid          = out_valid_reg;
    assign volume_level       = out_vol_reg;
    assign brightness_level   = out_bri_reg;
    assign volume_changed     = out_vol_chg_reg;
    assign brightness_changed = out_bri_chg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_delay_reg    <= vbkr_pkg::RST_REPEAT_DELAY;
            repeat_interval_reg <= vbkr_pkg::RST_REPEAT_INTERVAL;
            stale_gap_reg       <= vbkr_pkg::RST_STALE_GAP;
            volume_top_reg      <= vbkr_pkg::RST_VOLUME_TOP;
            brightness_top_reg  <= vbkr_pkg::RST_BRIGHTNESS_TOP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                vbkr_pkg::REG_REPEAT_DELAY:    repeat_delay_reg    <= cfg_data;
                vbkr_pkg::REG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data;
                vbkr_pkg::REG_STALE_GAP:       stale_gap_reg       <= cfg_data;
                vbkr_pkg::REG_VOLUME_TOP:      volume_top_reg      <= cfg_data[LW-1:0];
                vbkr_pkg::REG_BRIGHTNESS_TOP:  brightness_top_reg  <= cfg_data[LW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg       <= vbkr_pkg::op_t'(op);
            s1_elapsed_reg  <= elapsed_ms;
            s1_is_key_reg   <= is_key_event;
            s1_code_reg     <= key_code;
            s1_value_reg    <= vbkr_pkg::key_value_t'(key_value);
            s1_load_vol_reg <= load_volume;
            s1_load_bri_reg <= load_brightness;
        end
    end

    // per-word state update
    logic          key_ok;
    logic          key_on;
    logic          is_menu;
    logic [CW-1:0] delay_due;
    logic          held_p;
    logic          fresh_p;
    logic [CW-1:0] due_p;
    logic          held_m;
    logic          fresh_m;
    logic [CW-1:0] due_m;
    logic          menu_e;
    logic          fire_p;
    logic          fire_m;
    logic [LW-1:0] lvl_a;
    logic [LW-1:0] lvl_b;
    logic [LW-1:0] lvl_c;
    logic [LW-1:0] lvl_top;

    always_comb
    begin
        clock_next       = clock_reg;
        stale_next       = stale_reg;
        menu_next        = menu_reg;
        plus_held_next   = plus_held_reg;
        plus_fresh_next  = plus_fresh_reg;
        plus_due_next    = plus_due_reg;
        minus_held_next  = minus_held_reg;
        minus_fresh_next = minus_fresh_reg;
        minus_due_next   = minus_due_reg;
        volume_next      = volume_reg;
        bright_next      = bright_reg;

        key_ok    = !stale_reg && s1_is_key_reg && (s1_value_reg != vbkr_pkg::KEY_IGNORED);
        key_on    = (s1_value_reg != vbkr_pkg::KEY_RELEASE);
        is_menu   = s1_code_reg inside {vbkr_pkg::CODE_MENU_A, vbkr_pkg::CODE_MENU_B};
        delay_due = clock_reg + CW'(repeat_delay_reg);

        // a stale frame drops all key state before servicing
        held_p  = plus_held_reg && !stale_reg;
        fresh_p = plus_fresh_reg && !stale_reg;
        due_p   = stale_reg ? '0 : plus_due_reg;
        held_m  = minus_held_reg && !stale_reg;
        fresh_m = minus_fresh_reg && !stale_reg;
        due_m   = stale_reg ? '0 : minus_due_reg;
        menu_e  = menu_reg && !stale_reg;
        fire_p  = fresh_p || (held_p && (clock_reg >= due_p));
        fire_m  = fresh_m || (held_m && (clock_reg >= due_m));

        // plus steps first, then minus, on the same level
        lvl_a   = menu_e ? bright_reg : volume_reg;
        lvl_top = menu_e ? brightness_top_reg : volume_top_reg;
        lvl_b   = (fire_p && (lvl_a < lvl_top)) ? lvl_a + 1'b1 : lvl_a;
        lvl_c   = (fire_m && (lvl_b != '0)) ? lvl_b - 1'b1 : lvl_b;

        case (s1_op_reg)
            vbkr_pkg::OP_FRAME_BEGIN:
            begin
                clock_next = clock_reg + CW'(s1_elapsed_reg);
                stale_next = (s1_elapsed_reg > stale_gap_reg);
            end
            vbkr_pkg::OP_KEY_EVENT:
            begin
                if (key_ok)
                begin
                    if (is_menu)
                    begin
                        menu_next = key_on;
                    end
                    else if (s1_code_reg == vbkr_pkg::CODE_VOL_UP)
                    begin
                        plus_held_next  = key_on;
                        plus_fresh_next = key_on;
                        if (key_on)
                        begin
                            plus_due_next = delay_due;
                        end
                    end
                    else if (s1_code_reg == vbkr_pkg::CODE_VOL_DOWN)
                    begin
                        minus_held_next  = key_on;
                        minus_fresh_next = key_on;
                        if (key_on)
                        begin
                            minus_due_next = delay_due;
                        end
                    end
                end
            end
            vbkr_pkg::OP_FRAME_END:
            begin
                stale_next       = 1'b0;
                menu_next        = menu_e;
                plus_held_next   = held_p;
                minus_held_next  = held_m;
                // a fresh key always fires, so fresh is consumed here
                plus_fresh_next  = 1'b0;
                minus_fresh_next = 1'b0;
                plus_due_next    = (fire_p && !fresh_p) ?
                                   due_p + CW'(repeat_interval_reg) : due_p;
                minus_due_next   = (fire_m && !fresh_m) ?
                                   due_m + CW'(repeat_interval_reg) : due_m;
                if (menu_e)
                begin
                    bright_next = lvl_c;
                end
                else
                begin
                    volume_next = lvl_c;
                end
            end
            vbkr_pkg::OP_LOAD:
            begin
                volume_next = s1_load_vol_reg;
                bright_next = s1_load_bri_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            clock_reg       <= '0;
            stale_reg       <= 1'b0;
            menu_reg        <= 1'b0;
            plus_held_reg   <= 1'b0;
            plus_fresh_reg  <= 1'b0;
            plus_due_reg    <= '0;
            minus_held_reg  <= 1'b0;
            minus_fresh_reg <= 1'b0;
            minus_due_reg   <= '0;
            volume_reg      <= '0;
            bright_reg      <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                clock_reg       <= clock_next;
                stale_reg       <= stale_next;
                menu_reg        <= menu_next;
                plus_held_reg   <= plus_held_next;
                plus_fresh_reg  <= plus_fresh_next;
                plus_due_reg    <= plus_due_next;
                minus_held_reg  <= minus_held_next;
                minus_fresh_reg <= minus_fresh_next;
                minus_due_reg   <= minus_due_next;
                volume_reg      <= volume_next;
                bright_reg      <= bright_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_vol_reg     <= volume_next;
            out_bri_reg     <= bright_next;
            out_vol_chg_reg <= (volume_next != volume_reg);
            out_bri_chg_reg <= (bright_next != bright_reg);
        end
    end

endmodule

@@ design/vbkr_checker.sv @@
`timescale 1ns / 1ps
`include "volume_brightness_key_repeat_defines.svh"

module vbkr_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [vbkr_pkg::LEVEL_W-1:0]      volume_level,
    input  logic [vbkr_pkg::LEVEL_W-1:0]      brightness_level,
    input  logic                              volume_changed,
    input  logic                              brightness_changed
);

    // levels of the last delivered word, zero after reset
    logic [vbkr_pkg::LEVEL_W-1:0] prev_vol_reg;
    logic [vbkr_pkg::LEVEL_W-1:0] prev_bri_reg;
    logic [2*vbkr_pkg::LEVEL_W+1:0] out_word;

    assign out_word = {volume_level, brightness_level, volume_changed, brightness_changed};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_vol_reg <= '0;
            prev_bri_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            prev_vol_reg <= volume_level;
            prev_bri_reg <= brightness_level;
        end
    end

    `VBKR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `VBKR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_word))
    `VBKR_ASSERT_NOW(a_vol_flag, out_valid && out_ready, volume_changed == (volume_level != prev_vol_reg))
    `VBKR_ASSERT_NOW(a_bri_flag, out_valid && out_ready, brightness_changed == (brightness_level != prev_bri_reg))

endmodule

bind volume_brightness_key_repeat vbkr_checker u_vbkr_checker (.*);
